/* hw/rtl/dfsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsb_pkg
// Shared constants, codes and types of the dual free space bitmap unit.
// ----------------------------------------------------------------------------
package dfsb_pkg;

  localparam int DEF_MAX_BLOCKS = 4096;
  localparam int DEF_MAX_NODES  = 1024;
  localparam int DEF_WORD_BITS  = 64;

  localparam int KIND_W    = 3;
  localparam int IDX_W     = 12;
  localparam int STAT_W    = 2;
  localparam int BCNT_W    = 13;
  localparam int NCNT_W    = 11;
  localparam int POS_W     = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = BCNT_W;

  localparam logic [KIND_W-1:0] KIND_RAW_SET   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MARK_USED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MARK_FREE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND_FREE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 1'b1;

  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;
  localparam logic [NCNT_W-1:0] INODE_COUNT_RST = 11'd1024;

  // word update control: write one bit of the word with the given value
  typedef struct packed {
    logic put;
    logic value;
  } dfsb_wctl_t;

endpackage

/* hw/rtl/dfsb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dfsb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/dfsb_word_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsb_word_unit
// Bit read, bit update and lowest free bit search on one bitmap word.
// ----------------------------------------------------------------------------
module dfsb_word_unit #(
  parameter int LANE = 64,
  parameter int SH   = $clog2(LANE)
) (
  input  logic                word_i,
  input  logic [LANE-1:0]     data_i,
  input  logic [SH-1:0]       pos_i,
  input  dfsb_pkg::dfsb_wctl_t ctl_i,
  input  logic [SH:0]         valid_cnt_i,
  output logic [LANE-1:0]     data_o,
  output logic                bit_o,
  output logic                free_any_o,
  output logic [SH-1:0]       free_pos_o
);
  import dfsb_pkg::*;

  localparam int GRPS = LANE / 8;
  localparam int GW   = (SH > 3) ? SH - 3 : 1;

  logic [LANE-1:0] vmask;
  logic [LANE-1:0] freev;
  logic [GRPS-1:0] gany;
  logic [GW-1:0]   gsel;
  logic [SH-1:0]   gbase;
  logic [7:0]      gbits;
  logic [2:0]      bsel;

  assign bit_o = data_i[pos_i];

  always_comb begin
    data_o = data_i;
    if (ctl_i.put && word_i) begin
      data_o[pos_i] = ctl_i.value;
    end
  end

  always_comb begin
    for (int j = 0; j < LANE; j++) begin
      vmask[j] = ((SH + 1)'(j) < valid_cnt_i);
    end
  end

  assign freev = ~data_i & vmask;

  always_comb begin
    for (int g = 0; g < GRPS; g++) begin
      gany[g] = |freev[g*8 +: 8];
    end
  end

  always_comb begin
    gsel = '0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (gany[g]) begin
        gsel = GW'(g);
      end
    end
  end

  assign gbase = SH'({gsel, 3'b000});
  assign gbits = freev[gbase +: 8];

  always_comb begin
    bsel = '0;
    for (int b = 7; b >= 0; b--) begin
      if (gbits[b]) begin
        bsel = 3'(b);
      end
    end
  end

  assign free_any_o = |gany;
  assign free_pos_o = gbase | SH'(bsel);

endmodule

/* hw/rtl/dual_free_space_bitmap_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_free_space_bitmap_unit
// Two usage bitmaps (blocks, index nodes) in RAM with used-entry tallies:
// raw set, mark used, mark free, find lowest free entry and query.
//
//   channel  | ports                                           | handshake
//   ---------+-------------------------------------------------+-------------
//   command  | in_kind, in_map_select, in_entry_index,         | start, busy
//            | in_bit_value                                    |
//   result   | out_status, out_found_index, out_entry_used,    | out_valid
//            | out_free_left                                   |
//   config   | cfg_index, cfg_wdata                            | cfg_we
//
// Set, mark and query step through accept, RAM read and execute, the
// execute step writing the word back for set and mark; find repeats the
// execute step for each bitmap word scanned, one RAM read per word. The
// result strobes in the cycle after the last step; no result stall. After
// reset a pass over max(block, node) words zeroes the RAMs with busy high.
// ----------------------------------------------------------------------------
module dual_free_space_bitmap_unit #(
  parameter int MAX_BLOCKS = dfsb_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_NODES  = dfsb_pkg::DEF_MAX_NODES,
  parameter int WORD_BITS  = dfsb_pkg::DEF_WORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dfsb_pkg::KIND_W-1:0]    in_kind,
  input  logic                           in_map_select,
  input  logic [dfsb_pkg::IDX_W-1:0]     in_entry_index,
  input  logic                           in_bit_value,
  output logic                           out_valid,
  output logic [dfsb_pkg::STAT_W-1:0]    out_status,
  output logic [dfsb_pkg::IDX_W-1:0]     out_found_index,
  output logic                           out_entry_used,
  output logic [dfsb_pkg::BCNT_W-1:0]    out_free_left,
  input  logic                           cfg_we,
  input  logic [dfsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dfsb_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import dfsb_pkg::*;

  localparam int SH        = $clog2(WORD_BITS + 1) - 1;
  localparam int LANE      = 1 << SH;
  localparam int BLK_WORDS = (MAX_BLOCKS + LANE - 1) / LANE;
  localparam int NOD_WORDS = (MAX_NODES + LANE - 1) / LANE;
  localparam int BLK_AW    = (BLK_WORDS > 1) ? $clog2(BLK_WORDS) : 1;
  localparam int NOD_AW    = (NOD_WORDS > 1) ? $clog2(NOD_WORDS) : 1;
  localparam int WA_W      = (BLK_AW > NOD_AW) ? BLK_AW : NOD_AW;
  localparam int CLR_WORDS = (BLK_WORDS > NOD_WORDS) ? BLK_WORDS : NOD_WORDS;

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_RD, S_EX} state_t;

  state_t              state_r, state_nxt;
  logic [WA_W-1:0]     clr_r, clr_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic                sel_r, sel_nxt;
  logic [SH-1:0]       pos_r, pos_nxt;
  logic [WA_W-1:0]     word_r, word_nxt;
  logic                val_r, val_nxt;
  logic                in_range_r, in_range_nxt;
  logic [BCNT_W-1:0]   count_r, count_nxt;
  logic [BCNT_W-1:0]   tally_blk_r, tally_blk_nxt;
  logic [NCNT_W-1:0]   tally_nod_r, tally_nod_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [IDX_W-1:0]    out_found_r, out_found_nxt;
  logic                out_used_r, out_used_nxt;
  logic [BCNT_W-1:0]   out_free_r, out_free_nxt;
  logic [BCNT_W-1:0]   blk_cnt_r;
  logic [NCNT_W-1:0]   nod_cnt_r;

  logic [BCNT_W-1:0]   eff_blk, eff_nod, eff_sel;
  logic                accept;
  logic [POS_W-1:0]    base, rem_d;
  logic                last_word;
  logic [SH:0]         valid_cnt;
  logic [WA_W-1:0]     rd_word;
  logic                rd_en;
  logic                scan_more;
  logic [LANE-1:0]     blk_rdata, nod_rdata, rdata, wdata;
  logic                ex_bit, free_any;
  logic [SH-1:0]       free_pos;
  dfsb_wctl_t          wctl;
  logic                ex_put;
  logic                clearing;
  logic                blk_we, nod_we;
  logic [BCNT_W-1:0]   tally_after;
  logic [BCNT_W-1:0]   free_now;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cnt_r <= BLOCK_COUNT_RST;
      nod_cnt_r <= INODE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_COUNT: blk_cnt_r <= cfg_wdata;
        REG_INODE_COUNT: nod_cnt_r <= cfg_wdata[NCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_blk = (POS_W'(blk_cnt_r) > POS_W'(MAX_BLOCKS)) ? BCNT_W'(MAX_BLOCKS) : blk_cnt_r;
  assign eff_nod = (POS_W'(nod_cnt_r) > POS_W'(MAX_NODES)) ? BCNT_W'(MAX_NODES)
                                                           : BCNT_W'(nod_cnt_r);
  assign eff_sel = in_map_select ? eff_blk : eff_nod;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // word window of the scan
  assign base      = POS_W'(word_r) << SH;
  assign rem_d     = POS_W'(count_r) - base;
  assign last_word = (base + POS_W'(LANE)) >= POS_W'(count_r);
  assign valid_cnt = (POS_W'(count_r) <= base) ? '0 :
                     (last_word ? (SH + 1)'(rem_d) : (SH + 1)'(LANE));

  assign rdata = sel_r ? blk_rdata : nod_rdata;

  assign ex_put     = (state_r == S_EX) && in_range_r &&
                      (kind_r == KIND_RAW_SET || kind_r == KIND_MARK_USED ||
                       kind_r == KIND_MARK_FREE);
  assign wctl.put   = ex_put;
  assign wctl.value = (kind_r == KIND_RAW_SET) ? val_r : (kind_r == KIND_MARK_USED);

  assign scan_more = (state_r == S_EX) && (kind_r == KIND_FIND_FREE) &&
                     !free_any && !last_word;
  assign rd_word   = (state_r == S_EX) ? word_r + 1'b1 : word_r;
  assign rd_en     = (state_r == S_RD) || scan_more;

  assign clearing = (state_r == S_CLR);
  assign blk_we   = (clearing && ({1'b0, clr_r} < (WA_W + 1)'(BLK_WORDS))) || (ex_put && sel_r);
  assign nod_we   = (clearing && ({1'b0, clr_r} < (WA_W + 1)'(NOD_WORDS))) || (ex_put && !sel_r);

  dfsb_word_unit #(.LANE(LANE), .SH(SH)) u_word (
    .word_i      (1'b1),
    .data_i      (rdata),
    .pos_i       (pos_r),
    .ctl_i       (wctl),
    .valid_cnt_i (valid_cnt),
    .data_o      (wdata),
    .bit_o       (ex_bit),
    .free_any_o  (free_any),
    .free_pos_o  (free_pos)
  );

  dfsb_ram #(.WIDTH(LANE), .DEPTH(BLK_WORDS), .AW(BLK_AW)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (clearing ? clr_r[BLK_AW-1:0] : word_r[BLK_AW-1:0]),
    .wdata (clearing ? '0 : wdata),
    .re    (rd_en),
    .raddr (rd_word[BLK_AW-1:0]),
    .rdata (blk_rdata)
  );

  dfsb_ram #(.WIDTH(LANE), .DEPTH(NOD_WORDS), .AW(NOD_AW)) u_nod_ram (
    .clk   (clk),
    .we    (nod_we),
    .waddr (clearing ? clr_r[NOD_AW-1:0] : word_r[NOD_AW-1:0]),
    .wdata (clearing ? '0 : wdata),
    .re    (rd_en),
    .raddr (rd_word[NOD_AW-1:0]),
    .rdata (nod_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    kind_nxt       = kind_r;
    sel_nxt        = sel_r;
    pos_nxt        = pos_r;
    word_nxt       = word_r;
    val_nxt        = val_r;
    in_range_nxt   = in_range_r;
    count_nxt      = count_r;
    tally_blk_nxt  = tally_blk_r;
    tally_nod_nxt  = tally_nod_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_used_nxt   = out_used_r;
    out_free_nxt   = out_free_r;
    tally_after    = '0;
    free_now       = '0;

    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == WA_W'(CLR_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          kind_nxt     = in_kind;
          sel_nxt      = in_map_select;
          pos_nxt      = in_entry_index[SH-1:0];
          val_nxt      = in_bit_value;
          count_nxt    = eff_sel;
          in_range_nxt = (BCNT_W'(in_entry_index) < eff_sel);
          word_nxt     = (in_kind == KIND_FIND_FREE) ? '0 :
                         WA_W'(POS_W'(in_entry_index) >> SH);
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EX;
      end
      S_EX: begin
        out_status_nxt = ST_OK;
        out_found_nxt  = '0;
        out_used_nxt   = 1'b0;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
        unique case (kind_r)
          KIND_RAW_SET: begin
            if (!in_range_r) begin
              out_status_nxt = ST_RANGE;
            end
          end
          KIND_MARK_USED: begin
            if (!in_range_r) begin
              out_status_nxt = ST_RANGE;
            end else if (sel_r) begin
              if (tally_blk_r != '1) begin
                tally_blk_nxt = tally_blk_r + 1'b1;
              end
            end else if (tally_nod_r != '1) begin
              tally_nod_nxt = tally_nod_r + 1'b1;
            end
          end
          KIND_MARK_FREE: begin
            if (!in_range_r) begin
              out_status_nxt = ST_RANGE;
            end else if (sel_r) begin
              if (tally_blk_r != '0) begin
                tally_blk_nxt = tally_blk_r - 1'b1;
              end
            end else if (tally_nod_r != '0) begin
              tally_nod_nxt = tally_nod_r - 1'b1;
            end
          end
          KIND_FIND_FREE: begin
            if (free_any) begin
              out_found_nxt = IDX_W'(base + POS_W'(free_pos));
            end else if (last_word) begin
              out_status_nxt = ST_NONE;
            end else begin
              out_valid_nxt = 1'b0;
              word_nxt      = word_r + 1'b1;
              state_nxt     = S_EX;
            end
          end
          KIND_QUERY: begin
            if (!in_range_r) begin
              out_status_nxt = ST_RANGE;
              out_used_nxt   = 1'b1;
            end else begin
              out_used_nxt = ex_bit;
            end
          end
          default: ;
        endcase
        tally_after  = sel_r ? tally_blk_nxt : BCNT_W'(tally_nod_nxt);
        free_now     = (tally_after >= count_r) ? '0 : count_r - tally_after;
        out_free_nxt = free_now;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      tally_blk_r <= '0;
      tally_nod_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      tally_blk_r <= tally_blk_nxt;
      tally_nod_r <= tally_nod_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    sel_r        <= sel_nxt;
    pos_r        <= pos_nxt;
    word_r       <= word_nxt;
    val_r        <= val_nxt;
    in_range_r   <= in_range_nxt;
    count_r      <= count_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_used_r   <= out_used_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_entry_used  = out_used_r;
  assign out_free_left   = out_free_r;

  // results come only out of the execute step
  a_result_from_ex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EX))
    else $error("result strobe without execute step");

  // tallies only move in the execute step
  a_tally_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EX) |=> ($stable(tally_blk_r) && $stable(tally_nod_r)))
    else $error("tally changed outside execute step");

  // a transfer never yields a result in the following cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid)
    else $error("result too early after transfer");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_RANGE || out_status == ST_NONE))
    else $error("undefined status code");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found_index != '0) |-> (out_status == ST_OK))
    else $error("found index with failing status");

endmodule

/* tb/sv/dual_free_space_bitmap_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_free_space_bitmap_unit_test
// Self-checking bench for the dual free space bitmap unit. It keeps shadow
// copies of both usage maps, both tallies and both count registers, predicts
// the result of every accepted command and checks each result strobe against
// the oldest prediction. Stimulus is a short directed list followed by random
// commands, most often allocate pairs (find lowest free, then mark it used),
// mixed with frees, raw sets, queries and noise, across several count settings.
// ----------------------------------------------------------------------------
module dual_free_space_bitmap_unit_test;
  import dfsb_pkg::*;

  localparam int unsigned BLOCK_TALLY_MAX = (1 << BCNT_W) - 1;
  localparam int unsigned NODE_TALLY_MAX  = (1 << NCNT_W) - 1;
  localparam int unsigned IDX_MAX         = (1 << IDX_W) - 1;
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
  localparam bit MAP_NODE  = 1'b0;
  localparam bit MAP_BLOCK = 1'b1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              sel;
    logic [IDX_W-1:0]  idx;
    logic              val;
  } bitmap_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  found_index;
    logic              entry_used;
    logic [BCNT_W-1:0] free_left;
  } bitmap_result_t;

  class bitmap_scoreboard;
    bit [DEF_MAX_BLOCKS-1:0] block_map;
    bit [DEF_MAX_NODES-1:0]  node_map;
    int unsigned block_tally;
    int unsigned node_tally;
    int unsigned block_count;
    int unsigned inode_count;
    int errors;
    bitmap_result_t pending_results[$];

    function new();
      block_map   = '0;
      node_map    = '0;
      block_tally = 0;
      node_tally  = 0;
      block_count = BLOCK_COUNT_RST;
      inode_count = INODE_COUNT_RST;
      errors      = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == REG_BLOCK_COUNT) begin
        block_count = data;
      end else begin
        inode_count = data[NCNT_W-1:0];
      end
    endfunction

    function int unsigned eff_count(bit sel);
      if (sel) begin
        return (block_count > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : block_count;
      end
      return (inode_count > DEF_MAX_NODES) ? DEF_MAX_NODES : inode_count;
    endfunction

    function bit get_bit(bit sel, int unsigned i);
      return sel ? block_map[i] : node_map[i];
    endfunction

    function void put_bit(bit sel, int unsigned i, bit v);
      if (sel) begin
        block_map[i] = v;
      end else begin
        node_map[i] = v;
      end
    endfunction

    function int lowest_free(bit sel);
      int unsigned cnt;
      cnt = eff_count(sel);
      for (int unsigned i = 0; i < cnt; i++) begin
        if (!get_bit(sel, i)) return i;
      end
      return -1;
    endfunction

    function void move_tally(bit sel, bit up);
      if (sel) begin
        if (up && block_tally < BLOCK_TALLY_MAX) block_tally++;
        else if (!up && block_tally > 0) block_tally--;
      end else begin
        if (up && node_tally < NODE_TALLY_MAX) node_tally++;
        else if (!up && node_tally > 0) node_tally--;
      end
    endfunction

    function void note_command(bitmap_cmd_t c);
      bitmap_result_t r;
      int unsigned cnt;
      int unsigned tally;
      int lf;
      r = '0;
      cnt = eff_count(c.sel);
      case (c.kind)
        KIND_RAW_SET: begin
          if (c.idx >= cnt) r.status = ST_RANGE;
          else put_bit(c.sel, c.idx, c.val);
        end
        KIND_MARK_USED, KIND_MARK_FREE: begin
          if (c.idx >= cnt) begin
            r.status = ST_RANGE;
          end else begin
            put_bit(c.sel, c.idx, c.kind == KIND_MARK_USED);
            move_tally(c.sel, c.kind == KIND_MARK_USED);
          end
        end
        KIND_FIND_FREE: begin
          lf = lowest_free(c.sel);
          if (lf < 0) r.status = ST_NONE;
          else r.found_index = IDX_W'(lf);
        end
        KIND_QUERY: begin
          if (c.idx >= cnt) begin
            r.status     = ST_RANGE;
            r.entry_used = 1'b1;
          end else begin
            r.entry_used = get_bit(c.sel, c.idx);
          end
        end
        default: ;
      endcase
      tally = c.sel ? block_tally : node_tally;
      r.free_left = (tally >= cnt) ? '0 : BCNT_W'(cnt - tally);
      pending_results.push_back(r);
    endfunction

    function void check_result(bitmap_result_t seen);
      bitmap_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: status %0d", seen.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (seen.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, seen.status);
        errors++;
      end
      if (seen.found_index !== want.found_index) begin
        $error("found_index: expected %0d, got %0d", want.found_index, seen.found_index);
        errors++;
      end
      if (seen.entry_used !== want.entry_used) begin
        $error("entry_used: expected %0d, got %0d", want.entry_used, seen.entry_used);
        errors++;
      end
      if (seen.free_left !== want.free_left) begin
        $error("free_left: expected %0d, got %0d", want.free_left, seen.free_left);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind;
  logic                  in_map_select;
  logic [IDX_W-1:0]      in_entry_index;
  logic                  in_bit_value;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [IDX_W-1:0]      out_found_index;
  logic                  out_entry_used;
  logic [BCNT_W-1:0]     out_free_left;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DAT_W-1:0]  cfg_wdata;

  bitmap_scoreboard sb;
  int burst_left;
  int issued;
  int idle_cycles;

  dual_free_space_bitmap_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_map_select   (in_map_select),
    .in_entry_index  (in_entry_index),
    .in_bit_value    (in_bit_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_used  (out_entry_used),
    .out_free_left   (out_free_left),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin : monitor
    bitmap_result_t seen;
    bitmap_cmd_t    cmd;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        seen.status      = out_status;
        seen.found_index = out_found_index;
        seen.entry_used  = out_entry_used;
        seen.free_left   = out_free_left;
        sb.check_result(seen);
      end
      if (start && busy === 1'b0) begin
        cmd.kind = in_kind;
        cmd.sel  = in_map_select;
        cmd.idx  = in_entry_index;
        cmd.val  = in_bit_value;
        sb.note_command(cmd);
      end
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (out_valid === 1'b1 || (start && busy === 1'b0) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("dual_free_space_bitmap_unit test failed");
        $finish;
      end
    end
  end

  function automatic bitmap_cmd_t mk(logic [KIND_W-1:0] kind, bit sel, int unsigned idx,
                                     bit val);
    bitmap_cmd_t c;
    c.kind = kind;
    c.sel  = sel;
    c.idx  = IDX_W'(idx);
    c.val  = val;
    return c;
  endfunction

  // mostly in range, with extra weight on the last entry and the first one past it
  function automatic logic [IDX_W-1:0] pick_index(bit sel);
    int unsigned cnt;
    int unsigned r;
    cnt = sb.eff_count(sel);
    r = $urandom_range(0, 99);
    if (cnt != 0 && r < 8 && cnt <= IDX_MAX) return IDX_W'(cnt);
    if (cnt != 0 && r < 16) return IDX_W'(cnt - 1);
    if (cnt != 0 && r < 85) return IDX_W'($urandom_range(0, cnt - 1));
    return IDX_W'($urandom_range(0, IDX_MAX));
  endfunction

  // drive at the falling edge, hold until the transfer, then maybe drop into a gap
  task automatic issue(input bitmap_cmd_t c);
    start          = 1'b1;
    in_kind        = c.kind;
    in_map_select  = c.sel;
    in_entry_index = c.idx;
    in_bit_value   = c.val;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    issued++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(0, 10);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending() != 0 || busy !== 1'b0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_counts(logic [CFG_DAT_W-1:0] blocks, logic [CFG_DAT_W-1:0] nodes);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = REG_BLOCK_COUNT;
    cfg_wdata = blocks;
    @(negedge clk);
    cfg_index = REG_INODE_COUNT;
    cfg_wdata = nodes;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_item();
    bitmap_cmd_t c;
    int lf;
    int unsigned r;
    c.sel  = 1'($urandom_range(0, 1));
    c.val  = 1'($urandom_range(0, 1));
    c.idx  = pick_index(c.sel);
    c.kind = KIND_QUERY;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      // allocate: find the lowest free entry, then claim it
      c.kind = KIND_FIND_FREE;
      issue(c);
      lf = sb.lowest_free(c.sel);
      c.kind = KIND_MARK_USED;
      if (lf >= 0) c.idx = IDX_W'(lf);
    end else if (r < 45) begin
      c.kind = KIND_MARK_FREE;
    end else if (r < 55) begin
      c.kind = KIND_RAW_SET;
    end else if (r < 70) begin
      c.kind = KIND_QUERY;
    end else if (r < 80) begin
      c.kind = KIND_MARK_USED;
    end else if (r < 88) begin
      c.kind = KIND_FIND_FREE;
    end else if (r < 93) begin
      c.kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    end else begin
      c.kind = KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
      c.idx  = IDX_W'($urandom);
    end
    issue(c);
  endtask

  task automatic random_items(int n);
    int target;
    target = issued + n;
    while (issued < target) random_item();
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = KIND_RAW_SET;
    in_map_select  = MAP_NODE;
    in_entry_index = '0;
    in_bit_value   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_BLOCK_COUNT;
    cfg_wdata      = '0;
    burst_left     = 0;
    issued         = 0;
    idle_cycles    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, default counts
    issue(mk(KIND_QUERY, MAP_BLOCK, 0, 1'b0));
    issue(mk(KIND_QUERY, MAP_NODE, 1023, 1'b1));
    issue(mk(KIND_FIND_FREE, MAP_BLOCK, 4095, 1'b0));
    issue(mk(KIND_FIND_FREE, MAP_NODE, 0, 1'b1));
    issue(mk(KIND_MARK_USED, MAP_BLOCK, 0, 1'b0));
    issue(mk(KIND_MARK_USED, MAP_BLOCK, 4095, 1'b1));
    issue(mk(KIND_FIND_FREE, MAP_BLOCK, 0, 1'b0));
    issue(mk(KIND_RAW_SET, MAP_BLOCK, 1, 1'b1));
    issue(mk(KIND_FIND_FREE, MAP_BLOCK, 0, 1'b0));
    issue(mk(KIND_MARK_USED, MAP_NODE, 1023, 1'b0));
    issue(mk(KIND_QUERY, MAP_NODE, 1023, 1'b0));
    issue(mk(KIND_QUERY, MAP_NODE, 1024, 1'b0));
    issue(mk(KIND_MARK_USED, MAP_NODE, 4095, 1'b1));
    issue(mk(KIND_RAW_SET, MAP_NODE, 2048, 1'b1));
    issue(mk(KIND_MARK_FREE, MAP_NODE, 1024, 1'b0));
    issue(mk(KIND_MARK_USED, MAP_BLOCK, 4095, 1'b0));
    issue(mk(KIND_MARK_FREE, MAP_BLOCK, 1, 1'b0));
    issue(mk(KIND_MARK_FREE, MAP_NODE, 5, 1'b0));
    issue(mk(KIND_MARK_FREE, MAP_NODE, 5, 1'b1));
    issue(mk(KIND_RAW_SET, MAP_BLOCK, 1, 1'b0));
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++) begin
      issue(mk(KIND_W'(k), 1'(k), 4095 - k, 1'b1));
    end
    issue(mk(KIND_QUERY, MAP_BLOCK, 4095, 1'b0));
    issue(mk(KIND_FIND_FREE, MAP_NODE, 0, 1'b0));

    random_items(150);
    set_counts(13'h1FFF, 13'h1FFF);
    random_items(150);
    set_counts(13'd1, 13'd1);
    random_items(120);
    set_counts(13'd0, 13'd0);
    random_items(60);
    set_counts(13'd70, 13'd9);
    random_items(200);
    set_counts(CFG_DAT_W'($urandom_range(1, DEF_MAX_BLOCKS)),
               CFG_DAT_W'($urandom_range(1, DEF_MAX_NODES)));
    random_items(150);
    set_counts(13'd130, 13'd64);
    random_items(150);
    set_counts(13'd4096, 13'd1024);
    random_items(200);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("dual_free_space_bitmap_unit test passed");
    end else begin
      $display("dual_free_space_bitmap_unit test failed");
    end
    $finish;
  end

endmodule
